// ===== src/assert_macros.svh =====
// Assertion macros for the slot queue manager.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define A_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define A_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assert failed");
`else
`define A_IMPL(label, clk, rst_n, prop)
`define A_NORST(label, clk, prop)
`endif
`endif

// ===== src/psqm_pkg.sv =====
// Types and codes for the slot queue manager.
// No dependencies.
package psqm_pkg;
    localparam int CMD_W = 3;
    localparam int SLOT_W = 4;
    localparam int TICK_W = 16;
    localparam int STAT_W = 2;
    localparam int WOKE_W = 5;

    typedef enum logic [2:0] {
        CMD_ALLOC = 3'd0, CMD_RELEASE = 3'd1, CMD_MKRUN = 3'd2, CMD_TAKE = 3'd3,
        CMD_BLOCK = 3'd4, CMD_TICK = 3'd5, CMD_WAKE = 3'd6, CMD_DISP = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_FREE = 2'd0, ST_RUN = 2'd1, ST_BLK = 2'd2, ST_DET = 2'd3
    } t_qstate;

    localparam logic [1:0] STS_OK = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_WRONG = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SLOT_W-1:0] slot;
        logic [TICK_W-1:0] sleep_ticks;
    } t_in;

    typedef struct packed {
        logic [SLOT_W-1:0] result_slot;
        logic [STAT_W-1:0] status;
        logic [WOKE_W-1:0] woken_count;
    } t_out;
endpackage

// ===== src/psqm_if.sv =====
// Valid/ready channel interface carrying a packed payload.
// Depends on psqm_pkg only through the payload type parameter.
interface psqm_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== src/process_slot_queue_manager_unit.sv =====
// Slot queue manager: free/runnable/blocked circular linked queues of slots.
// Depends on psqm_pkg, psqm_if, assert_macros.svh.
//
// channel   dir  payload
// i_cmd     in   cmd, slot, sleep_ticks
// o_res     out  result_slot, status, woken_count
//
// Unlink and append steps do all list edits. Queue commands that succeed go to
// unlink (alloc, take) or append (release, mkrun, block); tick walks all slots,
// one per cycle; wake walks the blocked list, one entry per cycle, pausing to
// unlink and append each woken slot. Not ready while busy or while a result
// waits. Reset restores all slots to the free queue at once.
`include "assert_macros.svh"
module process_slot_queue_manager_unit #(
    parameter int SLOTS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    psqm_if.sink   i_cmd,
    psqm_if.source o_res
);
    import psqm_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HW = $clog2(SLOTS + 1);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [HW-1:0] NONE = HW'(SLOTS);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_DEC = 7'b0000010, S_UNL = 7'b0000100,
        S_APP = 7'b0001000, S_TICK = 7'b0010000, S_WAKE = 7'b0100000,
        S_OUT = 7'b1000000
    } t_state;

    logic [IW-1:0]     r_next [SLOTS];
    logic [IW-1:0]     r_prev [SLOTS];
    logic [1:0]        r_qst  [SLOTS];
    logic [TICK_W-1:0] r_cnt  [SLOTS];
    logic [HW-1:0]     r_head [3];
    logic [IW-1:0]     r_run;

    t_state            r_st;
    t_in               r_in;
    logic [IW-1:0]     r_s;       // slot under work
    logic [1:0]        r_tq;      // target queue for append
    logic [1:0]        r_uq;      // queue to unlink from
    logic              r_chain;   // wake: append after unlink, then continue
    logic [IW-1:0]     r_walk;
    logic [CW-1:0]     r_left;
    logic [WOKE_W-1:0] r_woke;
    t_out              r_out;

    logic              slot_ok;
    logic [IW-1:0]     sidx;
    logic [1:0]        qsel;
    logic [IW-1:0]     hd;
    logic [IW-1:0]     nx, pv, tl;

    assign i_cmd.ready = (r_st == S_IDLE);
    assign o_res.valid = (r_st == S_OUT);
    assign o_res.data  = r_out;

    assign slot_ok = ({{(32-SLOT_W){1'b0}}, r_in.slot} < 32'(SLOTS));
    assign sidx    = IW'(r_in.slot);
    assign qsel    = (r_in.cmd == CMD_ALLOC) ? 2'(ST_FREE) : 2'(ST_RUN);
    assign nx = r_next[r_s];
    assign pv = r_prev[r_s];
    assign hd = IW'(r_head[r_tq]);
    assign tl = r_prev[hd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            for (int i = 0; i < SLOTS; i++) begin
                r_next[i] <= IW'((i + 1) % SLOTS);
                r_prev[i] <= IW'((i + SLOTS - 1) % SLOTS);
                r_qst[i]  <= 2'(ST_FREE);
                r_cnt[i]  <= '0;
            end
            r_head[0] <= '0;
            r_head[1] <= NONE;
            r_head[2] <= NONE;
            r_run <= '0;
        end else begin
            unique case (r_st)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_in <= i_cmd.data;
                        r_st <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_out.result_slot <= r_in.slot;
                    r_out.status <= STS_OK;
                    r_out.woken_count <= '0;
                    r_chain <= 1'b0;
                    r_woke <= '0;
                    r_st <= S_OUT;
                    unique case (t_cmd'(r_in.cmd))
                        CMD_ALLOC, CMD_TAKE: begin
                            if (r_head[qsel] == NONE) begin
                                r_out.status <= STS_EMPTY;
                                r_out.result_slot <= '0;
                            end else begin
                                r_s <= IW'(r_head[qsel]);
                                r_uq <= qsel;
                                r_out.result_slot <= SLOT_W'(r_head[qsel]);
                                r_st <= S_UNL;
                            end
                        end
                        CMD_RELEASE, CMD_MKRUN, CMD_BLOCK: begin
                            if (!slot_ok || r_qst[sidx] != 2'(ST_DET)) begin
                                r_out.status <= STS_WRONG;
                            end else begin
                                r_s <= sidx;
                                r_tq <= (r_in.cmd == CMD_RELEASE) ? 2'(ST_FREE) :
                                        (r_in.cmd == CMD_MKRUN) ? 2'(ST_RUN) :
                                        2'(ST_BLK);
                                if (r_in.cmd == CMD_BLOCK) r_cnt[sidx] <= r_in.sleep_ticks;
                                r_st <= S_APP;
                            end
                        end
                        CMD_TICK, CMD_WAKE: begin
                            if (r_head[2] == NONE) begin
                                r_out.status <= STS_EMPTY;
                            end else begin
                                r_walk <= (r_in.cmd == CMD_TICK) ? '0 : IW'(r_head[2]);
                                r_left <= CW'(SLOTS);
                                r_st <= (r_in.cmd == CMD_TICK) ? S_TICK : S_WAKE;
                            end
                        end
                        CMD_DISP: begin
                            if (!slot_ok) r_out.status <= STS_WRONG;
                            else r_run <= sidx;
                        end
                        default: ;
                    endcase
                end
                S_UNL: begin
                    if (nx == r_s) begin
                        r_head[r_uq] <= NONE;
                    end else begin
                        r_next[pv] <= nx;
                        r_prev[nx] <= pv;
                        if (r_head[r_uq] == HW'(r_s)) r_head[r_uq] <= HW'(nx);
                    end
                    r_qst[r_s] <= 2'(ST_DET);
                    r_st <= r_chain ? S_APP : S_OUT;
                end
                S_APP: begin
                    if (r_head[r_tq] == NONE) begin
                        r_head[r_tq] <= HW'(r_s);
                        r_next[r_s] <= r_s;
                        r_prev[r_s] <= r_s;
                    end else begin
                        r_next[tl] <= r_s;
                        r_prev[r_s] <= tl;
                        r_next[r_s] <= hd;
                        r_prev[hd] <= r_s;
                    end
                    r_qst[r_s] <= r_tq;
                    if (r_chain) begin
                        r_chain <= 1'b0;
                        r_st <= (r_left == '0) ? S_OUT : S_WAKE;
                    end else begin
                        r_st <= S_OUT;
                    end
                end
                S_TICK: begin
                    if (r_qst[r_walk] == 2'(ST_BLK) && r_cnt[r_walk] != '0)
                        r_cnt[r_walk] <= r_cnt[r_walk] - 1'b1;
                    r_walk <= r_walk + 1'b1;
                    if (CW'(r_walk) == CW'(SLOTS - 1)) r_st <= S_OUT;
                end
                S_WAKE: begin
                    // walk stops after the old tail or when the list empties
                    if (r_head[2] == NONE || r_left == '0) begin
                        r_st <= S_OUT;
                    end else begin
                        r_walk <= r_next[r_walk];
                        if (r_next[r_walk] == r_walk || (r_next[r_walk] ==
                                IW'(r_head[2]) && r_head[2] != HW'(r_walk)))
                            r_left <= '0;
                        else
                            r_left <= r_left - 1'b1;
                        if (r_cnt[r_walk] == '0) begin
                            r_s <= r_walk;
                            r_uq <= 2'(ST_BLK);
                            r_tq <= 2'(ST_RUN);
                            r_chain <= 1'b1;
                            if (r_woke != 5'd31) begin
                                r_woke <= r_woke + 1'b1;
                                r_out.woken_count <= r_woke + 1'b1;
                            end
                            r_st <= S_UNL;
                        end
                    end
                end
                S_OUT: begin
                    if (o_res.ready) r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `A_IMPL(a_no_accept_busy, i_clk, i_rst_n, (r_st != S_IDLE) |-> !i_cmd.ready)
    `A_IMPL(a_out_hold, i_clk, i_rst_n, (o_res.valid && !o_res.ready) |=> $stable(o_res.data))
    `A_IMPL(a_status_range, i_clk, i_rst_n, o_res.valid |-> (o_res.data.status != 2'd3))
endmodule

// ===== sim/process_slot_queue_manager_unit_tb.sv =====
// Testbench for the slot queue manager: drives commands over the valid/ready
// channel, predicts each result with a behavioral queue model and compares.
// Depends on psqm_pkg, psqm_if and process_slot_queue_manager_unit.
module process_slot_queue_manager_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import psqm_pkg::*;

    localparam int NSLOT = 16;
    localparam logic [4:0] NIL = 5'd16;
    localparam int LIMIT = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    psqm_if #(.T(t_in)) cmd_ch ();
    psqm_if #(.T(t_out)) res_ch ();

    process_slot_queue_manager_unit #(.SLOTS(NSLOT)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd_ch.sink), .o_res(res_ch.source)
    );

    logic [3:0] nxt [NSLOT];
    logic [3:0] prv [NSLOT];
    t_qstate qst [NSLOT];
    logic [15:0] sleep_left [NSLOT];
    logic [4:0] qhead [3];
    t_out pending_results [$];
    int errors = 0, n_sent = 0, n_checked = 0, cycles = 0;
    int burst_left = 0;

    task automatic q_append(t_qstate q, logic [3:0] s);
        logic [3:0] t;
        if (qhead[q] == NIL) begin
            qhead[q] = {1'b0, s};
            nxt[s] = s;
            prv[s] = s;
        end else begin
            t = prv[qhead[q][3:0]];
            nxt[t] = s;
            prv[s] = t;
            nxt[s] = qhead[q][3:0];
            prv[qhead[q][3:0]] = s;
        end
        qst[s] = q;
    endtask

    task automatic q_unlink(t_qstate q, logic [3:0] s);
        logic [3:0] n, p;
        n = nxt[s];
        p = prv[s];
        if (n == s) qhead[q] = NIL;
        else begin
            nxt[p] = n;
            prv[n] = p;
            if (qhead[q] == {1'b0, s}) qhead[q] = {1'b0, n};
        end
        qst[s] = ST_DET;
    endtask

    task automatic predict_queue_op(t_in it, output t_out r);
        logic [3:0] order [NSLOT];
        int n;
        logic [3:0] p;
        t_qstate q;
        r.result_slot = it.slot;
        r.status = STS_OK;
        r.woken_count = '0;
        case (t_cmd'(it.cmd))
            CMD_ALLOC, CMD_TAKE: begin
                q = (t_cmd'(it.cmd) == CMD_ALLOC) ? ST_FREE : ST_RUN;
                if (qhead[q] == NIL) begin
                    r.status = STS_EMPTY;
                    r.result_slot = '0;
                end else begin
                    r.result_slot = qhead[q][3:0];
                    q_unlink(q, qhead[q][3:0]);
                end
            end
            CMD_RELEASE, CMD_MKRUN, CMD_BLOCK: begin
                if (qst[it.slot] != ST_DET) r.status = STS_WRONG;
                else if (t_cmd'(it.cmd) == CMD_RELEASE) q_append(ST_FREE, it.slot);
                else if (t_cmd'(it.cmd) == CMD_MKRUN) q_append(ST_RUN, it.slot);
                else begin
                    sleep_left[it.slot] = it.sleep_ticks;
                    q_append(ST_BLK, it.slot);
                end
            end
            CMD_TICK: begin
                if (qhead[ST_BLK] == NIL) r.status = STS_EMPTY;
                else for (int i = 0; i < NSLOT; i++)
                    if (qst[i] == ST_BLK && sleep_left[i] != 0) sleep_left[i]--;
            end
            CMD_WAKE: begin
                if (qhead[ST_BLK] == NIL) r.status = STS_EMPTY;
                else begin
                    n = 0;
                    p = qhead[ST_BLK][3:0];
                    do begin
                        order[n++] = p;
                        p = nxt[p];
                    end while ({1'b0, p} != qhead[ST_BLK] && n < NSLOT);
                    for (int i = 0; i < n; i++)
                        if (sleep_left[order[i]] == 0) begin
                            q_unlink(ST_BLK, order[i]);
                            q_append(ST_RUN, order[i]);
                            r.woken_count++;
                        end
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_cmd(t_cmd c, logic [3:0] s, logic [15:0] tk);
        t_in it;
        t_out r;
        it.cmd = c;
        it.slot = s;
        it.sleep_ticks = tk;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 20)) @(posedge i_clk);
            else @(posedge i_clk);
        end
        burst_left--;
        cmd_ch.valid <= 1'b1;
        cmd_ch.data <= it;
        do @(posedge i_clk); while (!cmd_ch.ready);
        predict_queue_op(it, r);
        pending_results.push_back(r);
        n_sent++;
        if (burst_left == 0) cmd_ch.valid <= 1'b0;
    endtask

    task automatic drain_results();
        if (burst_left != 0) cmd_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic test_directed_edges();
        send_cmd(CMD_TAKE, 4'd0, 16'd0);
        send_cmd(CMD_TICK, 4'd0, 16'd0);
        send_cmd(CMD_WAKE, 4'd0, 16'd0);
        send_cmd(CMD_RELEASE, 4'd3, 16'd0);
        send_cmd(CMD_ALLOC, 4'd0, 16'd0);
        send_cmd(CMD_ALLOC, 4'd0, 16'd0);
        send_cmd(CMD_BLOCK, 4'd0, 16'hFFFF);
        send_cmd(CMD_BLOCK, 4'd1, 16'd0);
        send_cmd(CMD_BLOCK, 4'd1, 16'd5);
        send_cmd(CMD_TICK, 4'd0, 16'd0);
        send_cmd(CMD_WAKE, 4'd0, 16'd0);
        send_cmd(CMD_WAKE, 4'd0, 16'd0);
        send_cmd(CMD_TAKE, 4'd0, 16'd0);
        send_cmd(CMD_MKRUN, 4'd1, 16'd0);
        send_cmd(CMD_DISP, 4'd15, 16'd0);
        send_cmd(CMD_DISP, 4'd0, 16'd0);
        for (int i = 0; i < 16; i++) send_cmd(CMD_ALLOC, 4'd0, 16'd0);
        drain_results();
    endtask

    task automatic test_full_wake();
        for (int i = 0; i < NSLOT; i++)
            if (qst[i] == ST_DET) send_cmd(CMD_BLOCK, 4'(i), 16'($urandom_range(0, 2)));
        repeat (3) send_cmd(CMD_TICK, 4'd0, 16'd0);
        send_cmd(CMD_WAKE, 4'd0, 16'd0);
        drain_results();
    endtask

    task automatic test_random_mix(int count);
        logic [3:0] s;
        int pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            s = 4'($urandom);
            if (pick < 70) begin
                for (int j = 0; j < 4; j++) begin
                    s = 4'($urandom);
                    if (qst[s] == ST_DET) break;
                end
            end
            case ($urandom_range(0, 9))
                0, 1: send_cmd(CMD_ALLOC, s, 16'($urandom));
                2: send_cmd(CMD_RELEASE, s, 16'($urandom));
                3: send_cmd(CMD_MKRUN, s, 16'($urandom));
                4: send_cmd(CMD_TAKE, s, 16'($urandom));
                5: send_cmd(CMD_BLOCK, s, ($urandom_range(0, 9) == 0) ?
                                          16'($urandom) : 16'($urandom_range(0, 4)));
                6: send_cmd(CMD_TICK, s, 16'($urandom));
                7: send_cmd(CMD_WAKE, s, 16'($urandom));
                default: send_cmd(CMD_DISP, s, 16'($urandom));
            endcase
        end
        drain_results();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 1'b0;
        else res_ch.ready <= ((cycles % 64) < 40) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", res_ch.data);
            end else begin
                if (res_ch.data !== pending_results[0]) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch #%0d: expected %p got %p", n_checked,
                                 pending_results[0], res_ch.data);
                end
                void'(pending_results.pop_front());
                n_checked++;
            end
        end
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL process_slot_queue_manager_unit");
            $finish;
        end
    end

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        res_ch.ready = 1'b0;
        for (int i = 0; i < NSLOT; i++) begin
            nxt[i] = 4'((i + 1) % NSLOT);
            prv[i] = 4'((i + NSLOT - 1) % NSLOT);
            qst[i] = ST_FREE;
            sleep_left[i] = '0;
        end
        qhead[ST_FREE] = 5'd0;
        qhead[ST_RUN] = NIL;
        qhead[ST_BLK] = NIL;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_edges();
        test_full_wake();
        test_random_mix(850);
        test_full_wake();
        test_random_mix(850);
        if (pending_results.size() != 0) errors++;
        $display("Ran %0d transactions, %0d results checked: pops, appends, sleep,",
                 n_sent, n_checked);
        $display("tick/wake and dispatch including empty-queue and wrong-state cases.");
        if (errors == 0) $display("PASS process_slot_queue_manager_unit");
        else $display("FAIL process_slot_queue_manager_unit");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+src
src/psqm_pkg.sv
src/psqm_if.sv
src/process_slot_queue_manager_unit.sv
sim/process_slot_queue_manager_unit_tb.sv
